// ===== design/byterun1_bitplane_decoder_assert.svh =====
// assertion macros used by the checker file bbd_checker.sv
`ifndef BYTERUN1_BITPLANE_DECODER_ASSERT_SVH
`define BYTERUN1_BITPLANE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define BBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define BBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bbd_pkg.sv =====
`default_nettype none

package bbd_pkg;

  // result queue depth between the decoder and the output port
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [10:0] ROW_BYTES_RST   = 11'd40;
  localparam logic [3:0]  PLANE_COUNT_RST = 4'd5;
  localparam logic [12:0] IMAGE_ROWS_RST  = 13'd256;

  // register limits
  localparam logic [10:0] ROW_BYTES_MAX   = 11'd1024;
  localparam logic [3:0]  PLANE_COUNT_MAX = 4'd8;
  localparam logic [12:0] IMAGE_ROWS_MAX  = 13'd4096;

  // packbits header codes
  localparam logic [7:0] HDR_NOP   = 8'd128;
  localparam logic [8:0] REP_LIMIT = 9'd257;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ROW_BYTES   = 3'd0,
    CFG_PLANE_COUNT = 3'd1,
    CFG_IMAGE_ROWS  = 3'd2,
    CFG_HAS_MASK    = 3'd3,
    CFG_COMPRESSED  = 3'd4
  } cfg_idx_t;

  // run decoder state
  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_LIT    = 2'd1,
    MODE_REP    = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  // one configuration write
  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [12:0] data;
  } cfg_wr_t;

  // one write command
  typedef struct packed {
    logic        image_end;
    logic        overrun;
    logic [9:0]  column;
    logic [11:0] row;
    logic [2:0]  plane;
    logic [7:0]  run_length;
    logic [7:0]  value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/byterun1_bitplane_decoder.sv =====
`default_nettype none

// channel  dir   handshake              payload
// in_      in    in_tvalid/in_tready    in_tdata: body byte
// out_     out   out_tvalid/out_tready  out_tdata, out_tuser, out_tlast: write command
// cfg_     in    cfg_valid/cfg_ready    cfg_index, cfg_data: register write
//
// One body byte is taken every cycle while in_tready is high; its write command, if any,
// is visible on out_ the cycle after the byte is accepted when no older command is waiting.
// The decoder feeds a QUEUE_DEPTH-entry command queue; in_tready drops only while
// that queue is full, i.e. after out_tready has been low for a while.
// Synchronous active-low reset clears the run state and positions and loads the
// registers with 40, 5, 256, 0, 1; there is no clearing pass. cfg_ready is always high.

module byterun1_bitplane_decoder #(
  parameter int QUEUE_DEPTH = bbd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // body byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] body_byte
  // write command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // [7:0] value, [15:8] run_length, [18:16] plane,
                                        // [30:19] row, [40:31] column, [47:41] zero
  output logic             out_tuser,   // [0] overrun
  output logic             out_tlast,   // image_end
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import bbd_pkg::*;

  cfg_wr_t cfg_wr;
  logic    in_fire;
  logic    cmd_push;
  cmd_t    cmd;
  logic    q_full;
  cmd_t    head;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_tready = ~q_full;
  assign in_fire   = in_tvalid & in_tready;

  // run decoding and position tracking
  bbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // command queue toward the output
  bbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (cmd),
    .full       (q_full),
    .head_valid (out_tvalid),
    .pop        (out_tready),
    .head       (head)
  );

  // output packing
  assign out_tdata = {7'd0, head.column, head.row, head.plane, head.run_length, head.value};
  assign out_tuser = head.overrun;
  assign out_tlast = head.image_end;

endmodule

`default_nettype wire

// ===== design/bbd_front.sv =====
`default_nettype none

module bbd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bbd_pkg::cfg_wr_t cfg_wr,
  input  wire logic           in_fire,
  input  wire logic [7:0]     in_byte,
  output logic                cmd_push,
  output bbd_pkg::cmd_t       cmd
);
  import bbd_pkg::*;

  logic [10:0] row_bytes_r;
  logic [3:0]  plane_count_r;
  logic [12:0] image_rows_r;
  logic        has_mask_r;
  logic        compressed_r;

  mode_t       mode_r, mode_d, mode_nxt;
  logic [7:0]  left_r, left_d, left_nxt, left_dec;
  logic [7:0]  pend_r, pend_d, pend_nxt;
  logic [10:0] col_r, col_nxt;
  logic [3:0]  plane_r, plane_nxt;
  logic [11:0] row_r, row_nxt;
  logic        mask_r, mask_nxt;

  logic [10:0] rb;
  logic [3:0]  pc;
  logic [12:0] rows;
  logic [10:0] col_e;
  logic [3:0]  plane_e;
  logic [11:0] row_e;
  logic        mask_e;
  logic        vis;

  logic        do_place;
  logic        emit;
  logic        ov;
  logic [7:0]  len;
  logic [7:0]  rep_len;
  logic [10:0] rem;
  logic [11:0] col_sum;
  logic        row_end;
  logic [3:0]  plane_inc;
  logic [12:0] row_inc;
  logic        wrap;
  logic        last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= ROW_BYTES_RST;
      plane_count_r <= PLANE_COUNT_RST;
      image_rows_r  <= IMAGE_ROWS_RST;
      has_mask_r    <= 1'b0;
      compressed_r  <= 1'b1;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_ROW_BYTES:   row_bytes_r   <= cfg_wr.data[10:0];
        CFG_PLANE_COUNT: plane_count_r <= cfg_wr.data[3:0];
        CFG_IMAGE_ROWS:  image_rows_r  <= cfg_wr.data;
        CFG_HAS_MASK:    has_mask_r    <= cfg_wr.data[0];
        CFG_COMPRESSED:  compressed_r  <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // clamp registers to their legal range
  always_comb begin
    if (row_bytes_r == 11'd0)               rb = 11'd1;
    else if (row_bytes_r > ROW_BYTES_MAX)   rb = ROW_BYTES_MAX;
    else                                    rb = row_bytes_r;
    if (plane_count_r == 4'd0)              pc = 4'd1;
    else if (plane_count_r > PLANE_COUNT_MAX) pc = PLANE_COUNT_MAX;
    else                                    pc = plane_count_r;
    if (image_rows_r == 13'd0)              rows = 13'd1;
    else if (image_rows_r > IMAGE_ROWS_MAX) rows = IMAGE_ROWS_MAX;
    else                                    rows = image_rows_r;
  end

  // positions folded back into range
  assign col_e   = (col_r >= rb) ? 11'd0 : col_r;
  assign plane_e = (plane_r >= pc) ? 4'd0 : plane_r;
  assign row_e   = ({1'b0, row_r} >= rows) ? 12'd0 : row_r;
  assign mask_e  = mask_r & has_mask_r;
  assign vis     = ~mask_e;

  assign left_dec = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
  assign rep_len  = (pend_r == 8'd0) ? 8'd1 : pend_r;
  assign rem      = rb - col_e;

  // classify the byte against the run state
  always_comb begin
    mode_d   = mode_r;
    left_d   = left_r;
    pend_d   = pend_r;
    do_place = 1'b0;
    emit     = 1'b0;
    ov       = 1'b0;
    len      = 8'd1;
    if (!compressed_r) begin
      mode_d   = MODE_HEADER;
      left_d   = 8'd0;
      do_place = 1'b1;
      emit     = vis;
    end else begin
      unique case (mode_r)
        MODE_HEADER: begin
          if (in_byte < HDR_NOP) begin
            left_d = in_byte + 8'd1;
            mode_d = MODE_LIT;
          end else if (in_byte > HDR_NOP) begin
            pend_d = 8'(REP_LIMIT - {1'b0, in_byte});
            mode_d = MODE_REP;
          end
        end
        MODE_LIT: begin
          left_d   = left_dec;
          ov       = ((col_e + 11'd1) >= rb) && (left_dec != 8'd0);
          if (ov)                    mode_d = MODE_DROP;
          else if (left_dec != 8'd0) mode_d = MODE_LIT;
          else                       mode_d = MODE_HEADER;
          do_place = 1'b1;
          emit     = vis;
        end
        MODE_REP: begin
          ov       = {3'd0, rep_len} > rem;
          len      = ov ? rem[7:0] : rep_len;
          mode_d   = MODE_HEADER;
          pend_d   = 8'd0;
          do_place = 1'b1;
          emit     = vis;
        end
        MODE_DROP: begin
          left_d = left_dec;
          if (left_dec == 8'd0) mode_d = MODE_HEADER;
        end
        default: ;
      endcase
    end
  end

  // advance column, plane, mask and row
  assign col_sum   = {1'b0, col_e} + {4'd0, len};
  assign row_end   = col_sum >= {1'b0, rb};
  assign plane_inc = plane_e + 4'd1;
  assign row_inc   = {1'b0, row_e} + 13'd1;

  always_comb begin
    col_nxt   = col_e;
    plane_nxt = plane_e;
    row_nxt   = row_e;
    mask_nxt  = mask_e;
    wrap      = 1'b0;
    if (do_place) begin
      if (!row_end) begin
        col_nxt = col_sum[10:0];
      end else begin
        col_nxt = 11'd0;
        if (mask_e || (plane_inc >= pc && !has_mask_r)) begin
          mask_nxt  = 1'b0;
          plane_nxt = 4'd0;
          if (row_inc >= rows) begin
            row_nxt = 12'd0;
            wrap    = 1'b1;
          end else begin
            row_nxt = row_inc[11:0];
          end
        end else if (plane_inc >= pc) begin
          plane_nxt = 4'd0;
          mask_nxt  = 1'b1;
        end else begin
          plane_nxt = plane_inc;
        end
      end
    end
  end

  // end of image drops whatever run is pending
  assign mode_nxt = wrap ? MODE_HEADER : mode_d;
  assign left_nxt = wrap ? 8'd0 : left_d;
  assign pend_nxt = wrap ? 8'd0 : pend_d;

  assign last = !mask_e && (plane_e == pc - 4'd1) &&
                ({1'b0, row_e} == rows - 13'd1) && row_end;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HEADER;
      left_r  <= 8'd0;
      pend_r  <= 8'd0;
      col_r   <= 11'd0;
      plane_r <= 4'd0;
      row_r   <= 12'd0;
      mask_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      plane_r <= plane_nxt;
      row_r   <= row_nxt;
      mask_r  <= mask_nxt;
    end
  end

  // write command toward the queue
  assign cmd_push       = in_fire && emit;
  assign cmd.value      = in_byte;
  assign cmd.run_length = len;
  assign cmd.plane      = plane_e[2:0];
  assign cmd.row        = row_e;
  assign cmd.column     = col_e[9:0];
  assign cmd.overrun    = ov;
  assign cmd.image_end  = last;

endmodule

`default_nettype wire

// ===== design/bbd_queue.sv =====
`default_nettype none

module bbd_queue #(
  parameter int DEPTH = bbd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bbd_pkg::cmd_t push_data,
  output logic               full,
  output logic               head_valid,
  input  wire logic          pop,
  output bbd_pkg::cmd_t      head
);
  import bbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/bbd_checker.sv =====
`default_nettype none

`include "byterun1_bitplane_decoder_assert.svh"

module bbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  logic        in_fire;
  logic        out_stall;
  logic [49:0] out_beat;
  logic        len_ok;
  logic [10:0] run_end;

  // handshake and beat views
  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tlast, out_tuser, out_tdata};
  assign len_ok    = (out_tdata[15:8] != 8'd0) && (out_tdata[15:8] <= 8'd128);
  assign run_end   = {1'b0, out_tdata[40:31]} + {3'd0, out_tdata[15:8]};

  // a stalled beat keeps its contents
  `BBD_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_beat), "stalled beat changed")

  // no result appears without an accepted byte
  `BBD_ASSERT_NEXT(a_no_spurious, !out_tvalid && !in_fire, !out_tvalid, "beat without input")

  // an empty queue always takes input
  `BBD_ASSERT_NOW(a_ready_empty, !out_tvalid, in_tready, "input stalled with empty queue")

  // run length stays within one to 128
  `BBD_ASSERT_NOW(a_len_range, out_tvalid, len_ok, "run length out of range")

  // a run never ends past column 1024, the largest legal row length
  `BBD_ASSERT_NOW(a_run_in_row, out_tvalid, run_end <= 11'd1024, "run crosses row end")

endmodule

bind byterun1_bitplane_decoder bbd_checker u_bbd_checker (.*);

`default_nettype wire

// ===== tb/byterun1_bitplane_decoder_checker.sv =====
`timescale 1ns / 100ps

module byterun1_bitplane_decoder_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        out_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  output int               error_count,
  output int               expected_count
);

  import bbd_pkg::*;

  localparam int MAX_PRINTED = 60;

  // shadow copy of the registers
  logic [10:0] row_bytes_reg;
  logic [3:0]  plane_count_reg;
  logic [12:0] image_rows_reg;
  logic        has_mask_reg;
  logic        compressed_reg;

  // run decoder and position state
  mode_t       run_mode;
  logic [7:0]  lit_left;
  logic [7:0]  rep_count;
  logic [10:0] col_pos;
  logic [3:0]  plane_idx;
  logic [11:0] row_idx;
  logic        mask_active;

  // write commands still owed by the block, oldest first
  cmd_t write_cmds_due[$];

  initial begin
    error_count    = 0;
    expected_count = 0;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED)
      $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
    if (got !== want)
      flag_error($sformatf("%s: got %0h expected %0h", name, got, want));
  endtask

  // 0 acts as 1, large values saturate
  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0)
      return 1;
    return (v > hi) ? hi : v;
  endfunction

  // move the write position past a run of len bytes
  task automatic advance_position(input int unsigned len, input int unsigned rb,
                                  input int unsigned pc, input int unsigned rows);
    bit row_done;
    row_done = 1'b0;
    if (col_pos + len < rb) begin
      col_pos = 11'(col_pos + len);
      return;
    end
    col_pos = '0;
    if (mask_active) begin
      mask_active = 1'b0;
      plane_idx   = '0;
      row_done    = 1'b1;
    end else begin
      plane_idx = plane_idx + 4'd1;
      if (plane_idx >= pc) begin
        plane_idx = '0;
        if (has_mask_reg)
          mask_active = 1'b1;
        else
          row_done = 1'b1;
      end
    end
    if (row_done) begin
      if (row_idx + 1 >= rows) begin
        // image complete: wrap and drop whatever run is pending
        row_idx   = '0;
        run_mode  = MODE_HEADER;
        lit_left  = '0;
        rep_count = '0;
      end else begin
        row_idx = row_idx + 12'd1;
      end
    end
  endtask

  // decode one body byte, queue the write command it causes
  task automatic decode_body_byte(input logic [7:0] b);
    int unsigned rb, pc, rows, len, rem;
    logic writes, ov, last, shown;
    cmd_t cmd;
    rb   = clamp_reg(row_bytes_reg, ROW_BYTES_MAX);
    pc   = clamp_reg(plane_count_reg, PLANE_COUNT_MAX);
    rows = clamp_reg(image_rows_reg, IMAGE_ROWS_MAX);
    writes = 1'b0;
    ov     = 1'b0;
    len    = 1;

    // positions left beyond shrunk registers restart at zero
    if (col_pos >= rb) col_pos = '0;
    if (plane_idx >= pc) plane_idx = '0;
    if (row_idx >= rows) row_idx = '0;
    if (!has_mask_reg) mask_active = 1'b0;
    shown = !mask_active;

    if (!compressed_reg) begin
      run_mode = MODE_HEADER;
      lit_left = '0;
      writes   = 1'b1;
    end else begin
      case (run_mode)
        MODE_HEADER: begin
          if (b < HDR_NOP) begin
            lit_left = b + 8'd1;
            run_mode = MODE_LIT;
          end else if (b > HDR_NOP) begin
            rep_count = 8'(REP_LIMIT - b);
            run_mode  = MODE_REP;
          end
        end
        MODE_LIT: begin
          if (lit_left != 0) lit_left = lit_left - 8'd1;
          // literal reaching the row end with bytes to spare: drop the rest
          ov = (col_pos + 1 >= rb) && (lit_left != 0);
          if (ov)
            run_mode = MODE_DROP;
          else
            run_mode = (lit_left != 0) ? MODE_LIT : MODE_HEADER;
          writes = 1'b1;
        end
        MODE_REP: begin
          rem = rb - col_pos;
          len = (rep_count == 0) ? 1 : rep_count;
          ov  = len > rem;
          if (ov) len = rem;
          run_mode  = MODE_HEADER;
          rep_count = '0;
          writes    = 1'b1;
        end
        default: begin
          if (lit_left != 0) lit_left = lit_left - 8'd1;
          if (lit_left == 0) run_mode = MODE_HEADER;
        end
      endcase
    end

    if (writes) begin
      last = !mask_active && (plane_idx + 1 == pc) && (row_idx + 1 == rows) &&
             (col_pos + len >= rb);
      if (shown) begin
        cmd.value      = b;
        cmd.run_length = 8'(len);
        cmd.plane      = plane_idx[2:0];
        cmd.row        = row_idx;
        cmd.column     = col_pos[9:0];
        cmd.overrun    = ov;
        cmd.image_end  = last;
        write_cmds_due.push_back(cmd);
      end
      advance_position(len, rb, pc, rows);
    end
  endtask

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      row_bytes_reg   = ROW_BYTES_RST;
      plane_count_reg = PLANE_COUNT_RST;
      image_rows_reg  = IMAGE_ROWS_RST;
      has_mask_reg    = 1'b0;
      compressed_reg  = 1'b1;
      run_mode        = MODE_HEADER;
      lit_left        = '0;
      rep_count       = '0;
      col_pos         = '0;
      plane_idx       = '0;
      row_idx         = '0;
      mask_active     = 1'b0;
      write_cmds_due.delete();
    end else begin
      // register write beat
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_BYTES:   row_bytes_reg   = cfg_data[10:0];
          CFG_PLANE_COUNT: plane_count_reg = cfg_data[3:0];
          CFG_IMAGE_ROWS:  image_rows_reg  = cfg_data[12:0];
          CFG_HAS_MASK:    has_mask_reg    = cfg_data[0];
          CFG_COMPRESSED:  compressed_reg  = cfg_data[0];
          default: ;
        endcase
      end
      // body byte beat
      if (in_tvalid && in_tready)
        decode_body_byte(in_tdata);
      // write command beat
      if (out_tvalid && out_tready) begin
        if (write_cmds_due.size() == 0) begin
          flag_error($sformatf("unexpected write command %0h", out_tdata));
        end else begin
          want = write_cmds_due.pop_front();
          compare_field("value", out_tdata[7:0], want.value);
          compare_field("run_length", out_tdata[15:8], want.run_length);
          compare_field("plane", out_tdata[18:16], want.plane);
          compare_field("row", out_tdata[30:19], want.row);
          compare_field("column", out_tdata[40:31], want.column);
          compare_field("tdata padding", out_tdata[47:41], '0);
          compare_field("overrun", out_tuser, want.overrun);
          compare_field("image_end", out_tlast, want.image_end);
        end
      end
    end
    expected_count = write_cmds_due.size();
  end

endmodule

// ===== tb/byterun1_bitplane_decoder_tb.sv =====
`timescale 1ns / 100ps

module byterun1_bitplane_decoder_tb;

  import bbd_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          ITEMS_PER_PHASE = 50;
  localparam int          SETTLE_CYCLES   = 6;
  localparam int          HOLD_CYCLES     = 300;
  localparam logic [2:0]  CFG_UNUSED      = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  int error_count;
  int expected_count;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_request;
  int cycle_count;

  byterun1_bitplane_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  byterun1_bitplane_decoder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .expected_count (expected_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run length guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one body byte beat, after random sender gaps
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly well-formed packets with random content, some noise
  task automatic send_packet(output int counted);
    int pick, n;
    pick    = $urandom_range(99);
    counted = 0;
    if (pick < 45) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(128, 1) : $urandom_range(6, 1);
      send_byte(8'(n - 1));
      repeat (n) send_byte(8'($urandom));
      counted = n + 1;
    end else if (pick < 85) begin
      n = ($urandom_range(4) == 0) ? $urandom_range(128, 2) : $urandom_range(8, 2);
      send_byte(8'(REP_LIMIT - n));
      send_byte(8'($urandom));
      counted = 2;
    end else if (pick < 90) begin
      send_byte(HDR_NOP);
    end else begin
      send_byte(8'($urandom));
      counted = 1;
    end
  endtask

  // drop valid, wait for every owed write, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // program the image geometry and coding, plus one write to an unused index
  task automatic set_image(input logic [12:0] rb, input logic [12:0] pc,
                           input logic [12:0] rows, input logic [12:0] mask,
                           input logic [12:0] comp);
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_PLANE_COUNT, pc);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_HAS_MASK, mask);
    write_reg(CFG_COMPRESSED, comp);
    write_reg(CFG_UNUSED, 13'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [12:0] rb, input logic [12:0] pc,
                           input logic [12:0] rows, input logic [12:0] mask,
                           input logic [12:0] comp, input int idle, input int stall,
                           input bit with_hold);
    int sent, got;
    bit held;
    sent = 0;
    held = 1'b0;
    settle();
    set_image(rb, pc, rows, mask, comp);
    idle_pct  = idle;
    stall_pct = stall;
    while (sent < ITEMS_PER_PHASE) begin
      send_packet(got);
      sent += got;
      // long receiver hold-off while bytes keep coming
      if (with_hold && !held && sent >= 8) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] seq_reset_cfg[$];
    logic [7:0] seq_small_img[$];
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROW_BYTES;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry: single literal, ignored header, short repeat, long repeat clipped
    seq_reset_cfg = '{8'h00, 8'hFF, HDR_NOP, 8'hFF, 8'h00, 8'h81, 8'hA5};
    foreach (seq_reset_cfg[i]) send_byte(seq_reset_cfg[i]);

    // tiny image with mask: literals, literal overrun and drop, mask runs, image end
    settle();
    set_image(13'd4, 13'd1, 13'd2, 13'd1, 13'd1);
    seq_small_img = '{8'h02, 8'h12, 8'h34, 8'h56,
                      8'h03, 8'h5A, 8'hC3, 8'h3C, 8'h99,
                      8'h83, 8'h77,
                      8'hFD, 8'h00,
                      HDR_NOP, 8'h01, 8'h11, 8'h22};
    foreach (seq_small_img[i]) send_byte(seq_small_img[i]);

    // random phases over geometries and flow-control patterns
    run_phase(13'd3, 13'd2, 13'd3, 13'd0, 13'd1, 0, 0, 1'b1);
    run_phase(13'd5, 13'd1, 13'd2, 13'd1, 13'd1, 85, 0, 1'b0);
    run_phase(13'd2, 13'd3, 13'd4, 13'd1, 13'd0, 0, 85, 1'b0);
    run_phase(13'd0, 13'd0, 13'd0, 13'd0, 13'd1, 20, 20, 1'b0);
    run_phase(13'd2047, 13'd15, 13'd8191, 13'd1, 13'd1, 0, 0, 1'b0);
    run_phase(13'd1024, 13'd8, 13'd4096, 13'd0, 13'd0, 85, 0, 1'b0);
    run_phase(13'd1, 13'd1, 13'd1, 13'd1, 13'd1, 0, 85, 1'b0);
    run_phase(13'd7, 13'd4, 13'd2, 13'd0, 13'd1, 20, 20, 1'b0);

    settle();
    if (error_count == 0 && expected_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
